// File: rtl/core/sfxm_pkg.sv
package sfxm_pkg;

  localparam int TEXT_W     = 64;
  localparam int SLEN_W     = 8;
  localparam int CHAR_W     = 8;
  localparam int RUN_W      = 4;
  localparam int CAP_W      = 5;
  localparam int USED_W     = 5;
  localparam int TEXT_BYTES = TEXT_W / 8;

  localparam logic [CHAR_W-1:0] DOT_CHAR = 8'h2E;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_CHAR   = 2'd1,
    OP_CLEAR  = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_NAME   = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_TOO_LONG = 2'd2,
    ST_PRESENT  = 2'd3
  } status_t;

endpackage

// File: rtl/core/suffix_table_name_match.sv
// A result is registered at the transfer of its item and is valid in the next cycle.
// Throughput: one item per cycle unless in_stall holds; the whole table is compared in parallel
// against the insert key or the name tail in the cycle of the transfer.
// Input stall rises only while a result waits and the output is stalled.
// Reset (rst_n, synchronous, active low) empties the table, clears the name
// tracking and the output valid, and sets the capacity register to 16.
module suffix_table_name_match
  import sfxm_pkg::*;
#(
  parameter int TABLE_DEPTH    = 16,
  parameter int MAX_SUFFIX_LEN = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [CAP_W-1:0]    cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_opcode,
  input  logic [TEXT_W-1:0]   in_suffix_text,
  input  logic [SLEN_W-1:0]   in_suffix_length,
  input  logic [CHAR_W-1:0]   in_name_char,
  input  logic                in_name_last,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_result_kind,
  output logic [1:0]          out_insert_status,
  output logic                out_suffix_matched,
  output logic [USED_W-1:0]   out_entries_used
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CMP_W = CNT_W + CAP_W;

  logic [CAP_W-1:0]  cfg_capacity_r;
  logic [TEXT_W-1:0] entry_text_r [TABLE_DEPTH];
  logic [RUN_W-1:0]  entry_len_r  [TABLE_DEPTH];
  logic [CNT_W-1:0]  entry_count_r, entry_count_nxt;
  logic [TEXT_W-1:0] tail_bytes_r, tail_bytes_nxt;
  logic [RUN_W-1:0]  tail_run_r, tail_run_nxt;
  logic              dot_seen_r, dot_seen_nxt;

  logic              out_valid_r;
  logic [1:0]        out_kind_r, out_kind_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic              out_matched_r, out_matched_nxt;
  logic [USED_W-1:0] out_used_r;

  logic              in_xfer;
  logic              produce;
  logic              entry_wr;
  logic [TEXT_W-1:0] masked_text;
  logic [TEXT_W-1:0] chr_bytes;
  logic [RUN_W-1:0]  chr_run;
  logic              chr_dot;
  logic [TEXT_W-1:0] key_text;
  logic [RUN_W-1:0]  key_len;
  logic              hit;
  logic              table_full;

  assign in_stall = out_valid_r && out_stall;
  assign in_xfer  = in_valid && !in_stall;

  assign out_valid          = out_valid_r;
  assign out_result_kind    = out_kind_r;
  assign out_insert_status  = out_status_r;
  assign out_suffix_matched = out_matched_r;
  assign out_entries_used   = out_used_r;

  always_comb begin
    masked_text = '0;
    chr_bytes   = tail_bytes_r;
    chr_run     = tail_run_r;
    chr_dot     = dot_seen_r;
    for (int b = 0; b < TEXT_BYTES; b++) begin
      if (in_suffix_length > SLEN_W'(b)) begin
        masked_text[8*b +: 8] = in_suffix_text[8*b +: 8];
      end
    end
    if (in_name_char == DOT_CHAR) begin
      chr_dot   = 1'b1;
      chr_run   = '0;
      chr_bytes = '0;
    end else if (tail_run_r < RUN_W'(MAX_SUFFIX_LEN)) begin
      for (int b = 0; b < TEXT_BYTES; b++) begin
        if (tail_run_r == RUN_W'(b)) begin
          chr_bytes[8*b +: 8] = in_name_char;
        end
      end
      chr_run = tail_run_r + 1'b1;
    end else begin
      chr_run = RUN_W'(MAX_SUFFIX_LEN + 1);
    end

    if (in_opcode == OP_INSERT) begin
      key_text = masked_text;
      key_len  = in_suffix_length[RUN_W-1:0];
    end else begin
      key_text = chr_bytes;
      key_len  = chr_run;
    end

    hit = 1'b0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (CNT_W'(i) < entry_count_r && entry_len_r[i] == key_len &&
          entry_text_r[i] == key_text) begin
        hit = 1'b1;
      end
    end

    table_full = (entry_count_r >= CNT_W'(TABLE_DEPTH)) ||
                 (CMP_W'(entry_count_r) >= CMP_W'(cfg_capacity_r));
  end

  always_comb begin
    entry_count_nxt = entry_count_r;
    tail_bytes_nxt  = tail_bytes_r;
    tail_run_nxt    = tail_run_r;
    dot_seen_nxt    = dot_seen_r;
    produce         = 1'b0;
    entry_wr        = 1'b0;
    out_kind_nxt    = KIND_INSERT;
    out_status_nxt  = ST_INSERTED;
    out_matched_nxt = 1'b0;
    case (in_opcode)
      OP_INSERT: begin
        produce = 1'b1;
        if (table_full) begin
          out_status_nxt = ST_FULL;
        end else if (in_suffix_length > SLEN_W'(MAX_SUFFIX_LEN)) begin
          out_status_nxt = ST_TOO_LONG;
        end else if (hit) begin
          out_status_nxt = ST_PRESENT;
        end else begin
          entry_wr        = 1'b1;
          entry_count_nxt = entry_count_r + 1'b1;
        end
      end
      OP_CHAR: begin
        if (in_name_last) begin
          produce         = 1'b1;
          out_kind_nxt    = KIND_NAME;
          out_matched_nxt = chr_dot && (chr_run != '0) &&
                            (chr_run <= RUN_W'(MAX_SUFFIX_LEN)) && hit;
          tail_bytes_nxt  = '0;
          tail_run_nxt    = '0;
          dot_seen_nxt    = 1'b0;
        end else begin
          tail_bytes_nxt = chr_bytes;
          tail_run_nxt   = chr_run;
          dot_seen_nxt   = chr_dot;
        end
      end
      OP_CLEAR: begin
        produce         = 1'b1;
        out_kind_nxt    = KIND_CLEAR;
        entry_count_nxt = '0;
      end
      default: begin
        produce = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_capacity_r <= CAP_W'(16);
      entry_count_r  <= '0;
      tail_bytes_r   <= '0;
      tail_run_r     <= '0;
      dot_seen_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cfg_capacity_r <= cfg_wr_data;
      end
      if (in_xfer) begin
        entry_count_r <= entry_count_nxt;
        tail_bytes_r  <= tail_bytes_nxt;
        tail_run_r    <= tail_run_nxt;
        dot_seen_r    <= dot_seen_nxt;
      end
      if (!out_valid_r || !out_stall) begin
        out_valid_r <= in_xfer && produce;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && entry_wr) begin
      entry_text_r[entry_count_r[IDX_W-1:0]] <= masked_text;
      entry_len_r[entry_count_r[IDX_W-1:0]]  <= in_suffix_length[RUN_W-1:0];
    end
    if (!out_valid_r || !out_stall) begin
      out_kind_r    <= out_kind_nxt;
      out_status_r  <= out_status_nxt;
      out_matched_r <= out_matched_nxt;
      out_used_r    <= USED_W'(entry_count_nxt);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    entry_count_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_clear_ack: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_opcode == OP_CLEAR) |=>
      (out_valid && out_result_kind == KIND_CLEAR && out_entries_used == '0))
    else $error("clear transfer not acknowledged with empty table");

  a_char_keeps_table: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_opcode == OP_CHAR) |=> $stable(entry_count_r))
    else $error("name character changed the table");

  a_tail_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tail_run_r <= RUN_W'(MAX_SUFFIX_LEN + 1))
    else $error("tail run beyond saturation");

endmodule

// File: sim/tb_suffix_table_name_match.sv
`timescale 1ns / 100ps

import sfxm_pkg::*;

localparam int TABLE_SLOTS = 16;
localparam int SUFFIX_MAX  = 8;
localparam logic [1:0] OP_UNUSED = 2'd3;

typedef struct {
  kind_t               kind;
  status_t             status;
  logic                matched;
  logic [USED_W-1:0]   used;
} verdict_t;

typedef logic [CHAR_W-1:0] char_q_t[$];

function automatic logic [TEXT_W-1:0] byte_mask(input int unsigned len);
  if (len >= TEXT_BYTES) return '1;
  return (64'd1 << (8 * len)) - 64'd1;
endfunction

class suffix_scoreboard;
  logic [TEXT_W-1:0] entry_text [TABLE_SLOTS];
  logic [SLEN_W-1:0] entry_len [TABLE_SLOTS];
  int unsigned       entry_count;
  int unsigned       capacity;
  logic [TEXT_W-1:0] tail_bytes;
  int unsigned       tail_run;
  bit                dot_seen;
  verdict_t          verdict_q[$];
  int unsigned       failures;

  function new();
    entry_count = 0;
    capacity    = 16;
    tail_bytes  = '0;
    tail_run    = 0;
    dot_seen    = 1'b0;
    failures    = 0;
  endfunction

  function bit holds(input logic [TEXT_W-1:0] text, input int unsigned len);
    for (int i = 0; i < entry_count && i < TABLE_SLOTS; i++) begin
      if (entry_len[i] == len && entry_text[i] == text) return 1'b1;
    end
    return 1'b0;
  endfunction

  function void flag(input string msg);
    failures++;
    if (failures <= 10) $display("mismatch: %s", msg);
  endfunction

  function void note_input(input logic [1:0] op, input logic [TEXT_W-1:0] text,
                           input logic [SLEN_W-1:0] slen, input logic [CHAR_W-1:0] ch,
                           input logic last);
    verdict_t          v;
    int unsigned       bound;
    logic [TEXT_W-1:0] key;
    v.kind    = KIND_INSERT;
    v.status  = ST_INSERTED;
    v.matched = 1'b0;
    case (op)
      OP_INSERT: begin
        bound = (capacity > TABLE_SLOTS) ? TABLE_SLOTS : capacity;
        if (entry_count >= bound) begin
          v.status = ST_FULL;
        end else if (slen > SUFFIX_MAX) begin
          v.status = ST_TOO_LONG;
        end else begin
          key = text & byte_mask(slen);
          if (holds(key, slen)) begin
            v.status = ST_PRESENT;
          end else begin
            entry_text[entry_count] = key;
            entry_len[entry_count]  = slen;
            entry_count++;
          end
        end
      end
      OP_CHAR: begin
        if (ch == DOT_CHAR) begin
          dot_seen   = 1'b1;
          tail_run   = 0;
          tail_bytes = '0;
        end else if (tail_run < SUFFIX_MAX) begin
          tail_bytes |= TEXT_W'(ch) << (8 * tail_run);
          tail_run++;
        end else begin
          tail_run = SUFFIX_MAX + 1;
        end
        if (!last) return;
        v.kind    = KIND_NAME;
        v.matched = dot_seen && tail_run >= 1 && tail_run <= SUFFIX_MAX
                    && holds(tail_bytes, tail_run);
        tail_bytes = '0;
        tail_run   = 0;
        dot_seen   = 1'b0;
      end
      OP_CLEAR: begin
        entry_count = 0;
        v.kind      = KIND_CLEAR;
      end
      default: return;
    endcase
    v.used = USED_W'(entry_count);
    verdict_q.push_back(v);
  endfunction

  function void check_result(input logic [1:0] kind, input logic [1:0] status,
                             input logic matched, input logic [USED_W-1:0] used);
    verdict_t v;
    if (verdict_q.size() == 0) begin
      flag($sformatf("unexpected transfer: kind %0d status %0d matched %0d used %0d",
                     kind, status, matched, used));
      return;
    end
    v = verdict_q.pop_front();
    if (kind !== v.kind || status !== v.status || matched !== v.matched || used !== v.used)
      flag($sformatf("exp kind %0d status %0d matched %0d used %0d, got %0d %0d %0d %0d",
                     v.kind, v.status, v.matched, v.used, kind, status, matched, used));
  endfunction

  function void check_drained();
    if (verdict_q.size() != 0)
      flag($sformatf("%0d results never arrived", verdict_q.size()));
  endfunction
endclass

module tb_suffix_table_name_match;

  localparam int LIMIT       = 400000;
  localparam int PHASE_ITEMS = 135;
  localparam int POOL_SIZE   = 24;
  localparam int unsigned PHASE_CAP [8] = '{16, 1, 31, 0, 5, 16, 2, 8};
  localparam int unsigned SEND_IDLE [4] = '{0, 57, 0, 30};
  localparam int unsigned RECV_STALL [4] = '{0, 0, 57, 30};

  logic                clk              = 1'b0;
  logic                rst_n            = 1'b0;
  logic                cfg_wr_en        = 1'b0;
  logic [CAP_W-1:0]    cfg_wr_data      = '0;
  logic                in_valid         = 1'b0;
  logic                in_stall;
  logic [1:0]          in_opcode        = OP_INSERT;
  logic [TEXT_W-1:0]   in_suffix_text   = '0;
  logic [SLEN_W-1:0]   in_suffix_length = '0;
  logic [CHAR_W-1:0]   in_name_char     = '0;
  logic                in_name_last     = 1'b0;
  logic                out_valid;
  logic                out_stall        = 1'b0;
  logic [1:0]          out_result_kind;
  logic [1:0]          out_insert_status;
  logic                out_suffix_matched;
  logic [USED_W-1:0]   out_entries_used;

  suffix_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned cycle_count   = 0;
  int unsigned items_sent    = 0;
  logic [TEXT_W-1:0] pool_text [POOL_SIZE];
  int unsigned       pool_len [POOL_SIZE];

  suffix_table_name_match uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_suffix_text     (in_suffix_text),
    .in_suffix_length   (in_suffix_length),
    .in_name_char       (in_name_char),
    .in_name_last       (in_name_last),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result_kind    (out_result_kind),
    .out_insert_status  (out_insert_status),
    .out_suffix_matched (out_suffix_matched),
    .out_entries_used   (out_entries_used)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("suffix_table_name_match regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_result_kind, out_insert_status, out_suffix_matched,
                      out_entries_used);
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  function automatic logic [TEXT_W-1:0] rand_text();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [CHAR_W-1:0] plain_char();
    logic [CHAR_W-1:0] c;
    c = CHAR_W'($urandom_range(0, 255));
    while (c == DOT_CHAR) c = CHAR_W'($urandom_range(0, 255));
    return c;
  endfunction

  task automatic send_item(input logic [1:0] op, input logic [TEXT_W-1:0] text,
                           input logic [SLEN_W-1:0] slen, input logic [CHAR_W-1:0] ch,
                           input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_opcode        <= op;
    in_suffix_text   <= text;
    in_suffix_length <= slen;
    in_name_char     <= ch;
    in_name_last     <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(op, text, slen, ch, last);
    if (op != OP_UNUSED) items_sent++;
  endtask

  task automatic send_insert(input logic [TEXT_W-1:0] text, input logic [SLEN_W-1:0] slen);
    send_item(OP_INSERT, text, slen, CHAR_W'($urandom_range(0, 255)),
              1'($urandom_range(0, 1)));
  endtask

  task automatic send_char(input logic [CHAR_W-1:0] ch, input logic last);
    send_item(OP_CHAR, rand_text(), SLEN_W'($urandom_range(0, 255)), ch, last);
  endtask

  task automatic send_clear();
    send_item(OP_CLEAR, rand_text(), SLEN_W'($urandom_range(0, 255)),
              CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic random_insert();
    logic [TEXT_W-1:0] text;
    int unsigned       len;
    int unsigned       k;
    int unsigned       r;
    text = rand_text();
    r    = $urandom_range(0, 99);
    if (r < 40 && sb.entry_count > 0) begin
      k    = $urandom_range(0, sb.entry_count - 1);
      len  = sb.entry_len[k];
      text = sb.entry_text[k] | (text & ~byte_mask(len));
    end else if (r < 80) begin
      k    = $urandom_range(0, POOL_SIZE - 1);
      len  = pool_len[k];
      text = pool_text[k] | (text & ~byte_mask(len));
    end else if (r < 90) begin
      len = $urandom_range(0, SUFFIX_MAX);
    end else begin
      len = $urandom_range(SUFFIX_MAX + 1, 255);
    end
    send_insert(text, SLEN_W'(len));
  endtask

  task automatic send_name(input char_q_t chars, input bit mix);
    for (int i = 0; i < chars.size(); i++) begin
      if (mix && i > 0 && $urandom_range(0, 99) < 4) begin
        if ($urandom_range(0, 1)) random_insert();
        else send_clear();
      end
      send_char(chars[i], i == chars.size() - 1);
    end
  endtask

  task automatic random_name();
    char_q_t           chars;
    logic [TEXT_W-1:0] text;
    int unsigned       len;
    int unsigned       k;
    int unsigned       r;
    repeat ($urandom_range(0, 5))
      chars.push_back(($urandom_range(0, 9) == 0) ? DOT_CHAR : plain_char());
    r = $urandom_range(0, 99);
    if (r < 70) begin
      if (r < 45 && sb.entry_count > 0) begin
        k    = $urandom_range(0, sb.entry_count - 1);
        text = sb.entry_text[k];
        len  = sb.entry_len[k];
      end else begin
        k    = $urandom_range(0, POOL_SIZE - 1);
        text = pool_text[k];
        len  = pool_len[k];
      end
      chars.push_back(DOT_CHAR);
      for (int i = 0; i < len; i++) chars.push_back(text[8*i +: 8]);
      if (r < 10) chars.push_back(plain_char());
    end else if (r < 80) begin
      chars.push_back(DOT_CHAR);
      repeat ($urandom_range(SUFFIX_MAX + 1, SUFFIX_MAX + 4)) chars.push_back(plain_char());
    end else if (r < 88) begin
      chars.push_back(DOT_CHAR);
    end else begin
      repeat ($urandom_range(1, 6)) chars.push_back(plain_char());
    end
    send_name(chars, 1'b1);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.capacity = value;
  endtask

  initial begin
    logic [TEXT_W-1:0] junk;
    int unsigned       target;
    int unsigned       r;
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_len[i]  = $urandom_range(1, SUFFIX_MAX);
      pool_text[i] = '0;
      for (int j = 0; j < pool_len[i]; j++) pool_text[i][8*j +: 8] = plain_char();
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty suffix, over-long lengths, full-width key, ignored upper bytes
    send_insert(rand_text(), SLEN_W'(0));
    send_insert(rand_text(), SLEN_W'(0));
    send_insert(rand_text(), SLEN_W'(SUFFIX_MAX + 1));
    send_insert('1, 8'hFF);
    send_insert('1, SLEN_W'(SUFFIX_MAX));
    junk = rand_text();
    send_insert({junk[63:16], 8'h78, 8'h74}, SLEN_W'(2));
    junk = rand_text();
    send_insert({junk[63:16], 8'h78, 8'h74}, SLEN_W'(2));
    send_insert({junk[63:8], 8'h00}, SLEN_W'(1));
    send_name('{DOT_CHAR, 8'h74, 8'h78}, 1'b0);
    send_name('{8'h61, DOT_CHAR}, 1'b0);
    send_name('{8'h74}, 1'b0);
    send_name('{DOT_CHAR, 8'h00}, 1'b0);
    // table emptied mid-name, tracking kept
    send_char(DOT_CHAR, 1'b0);
    send_char(8'h74, 1'b0);
    send_clear();
    send_char(8'h78, 1'b1);
    send_item(OP_UNUSED, rand_text(), SLEN_W'($urandom_range(0, 255)),
              CHAR_W'($urandom_range(0, 255)), 1'b1);
    write_capacity(CAP_W'(0));
    send_insert(junk, SLEN_W'(1));
    write_capacity(CAP_W'(31));
    send_insert(junk, SLEN_W'(1));

    for (int p = 0; p < 8; p++) begin
      write_capacity(CAP_W'(PHASE_CAP[p]));
      send_idle_pct = SEND_IDLE[p % 4];
      stall_pct     = RECV_STALL[p % 4];
      target        = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        r = $urandom_range(0, 99);
        if (r < 30) random_insert();
        else if (r < 85) random_name();
        else if (r < 88) send_clear();
        else if (r < 91)
          send_item(OP_UNUSED, rand_text(), SLEN_W'($urandom_range(0, 255)),
                    CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        else send_char(CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
    end

    drain();
    sb.check_drained();
    if (sb.failures == 0) begin
      $display("suffix_table_name_match regression: pass");
    end else begin
      $display("suffix_table_name_match regression: fail");
    end
    $finish;
  end

endmodule
